/* src/fati_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the four-axis table interpolator.
// Depends on nothing; the front end, back end, top level and bench take names from here by scope.
package fati_pkg;

	localparam int unsigned STORE_DEPTH = 32768;
	localparam int IDX_W = 7;
	localparam logic signed [27:0] DEG360_Q = 28'sd23592960;
	localparam logic signed [31:0] FRAC_LIM = 32'sd1073741824;

	typedef enum logic [2:0] {
		REG_DIR_MIN  = 3'd0,
		REG_DIR_RCP  = 3'd1,
		REG_SPD_MIN  = 3'd2,
		REG_SPD_RCP  = 3'd3,
		REG_INC_MIN  = 3'd4,
		REG_INC_RCP  = 3'd5,
		REG_SWH_MIN  = 3'd6,
		REG_SWH_RCP  = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		K_WRITE,
		K_QUERY,
		K_NULL
	} kind_t;

	// Axis levels follow the reduction order: 0 incidence, 1 speed, 2 direction, 3 wave.
	typedef struct packed {
		kind_t             kind;
		logic [14:0]       addr;
		logic [31:0]       value;
		logic [1:0]        pol;
		logic              nowave;
		logic [3:0][32:0]  delta;
	} entry_t;

	typedef struct packed {
		logic [3:0][31:0] recip;
	} recip_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AXMUL,
		ST_AXPOST,
		ST_READ,
		ST_MERGE,
		ST_LFIN,
		ST_EMIT
	} state_t;

endpackage

/* src/fati_in_if.sv */
`timescale 1ns / 1ps
// Input channel of the interpolator: valid/ready plus one command item.
// Depends on nothing.
interface fati_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [14:0]        entry_address;
	logic signed [31:0] entry_value;
	logic [1:0]         pol_index;
	logic signed [31:0] incidence;
	logic signed [31:0] speed;
	logic signed [26:0] direction;
	logic signed [31:0] wave_height;

	modport source(output valid, command, entry_address, entry_value, pol_index,
		incidence, speed, direction, wave_height, input ready);
	modport sink(input valid, command, entry_address, entry_value, pol_index,
		incidence, speed, direction, wave_height, output ready);
endinterface

/* src/fati_out_if.sv */
`timescale 1ns / 1ps
// Result channel of the interpolator: valid/ready plus the interpolated value.
// Depends on nothing.
interface fati_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;

	modport source(output valid, value, input ready);
	modport sink(input valid, value, output ready);
endinterface

/* src/fati_front.sv */
`timescale 1ns / 1ps
// Front end: configuration registers, command classification, direction wrap,
// axis offsets and a two-entry queue toward the back end. Uses fati_pkg, fati_in_if.
module fati_front #(
	parameter int POL_COUNT = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	fati_in_if.sink              din,
	input  logic                 wr_en,
	input  logic [2:0]           wr_index,
	input  logic [31:0]          wr_data,
	input  logic                 pop,
	output fati_pkg::entry_t     head,
	output logic                 head_v,
	output fati_pkg::recip_t     rcp
);

	logic signed [25:0] dir_min_q;
	logic signed [31:0] spd_min_q;
	logic signed [31:0] inc_min_q;
	logic [30:0]        swh_min_q;
	logic [31:0]        dir_rcp_q, spd_rcp_q, inc_rcp_q, swh_rcp_q;

	fati_pkg::entry_t fifo_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	fati_pkg::entry_t ent;
	logic signed [27:0] t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_min_q <= '0;
			spd_min_q <= '0;
			inc_min_q <= '0;
			swh_min_q <= '0;
			dir_rcp_q <= 32'd65536;
			spd_rcp_q <= 32'd65536;
			inc_rcp_q <= 32'd65536;
			swh_rcp_q <= 32'd65536;
		end else if (wr_en) begin
			unique case (fati_pkg::reg_idx_t'(wr_index))
				fati_pkg::REG_DIR_MIN: dir_min_q <= wr_data[25:0];
				fati_pkg::REG_DIR_RCP: dir_rcp_q <= wr_data;
				fati_pkg::REG_SPD_MIN: spd_min_q <= wr_data;
				fati_pkg::REG_SPD_RCP: spd_rcp_q <= wr_data;
				fati_pkg::REG_INC_MIN: inc_min_q <= wr_data;
				fati_pkg::REG_INC_RCP: inc_rcp_q <= wr_data;
				fati_pkg::REG_SWH_MIN: swh_min_q <= wr_data[30:0];
				fati_pkg::REG_SWH_RCP: swh_rcp_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign rcp.recip[0] = inc_rcp_q;
	assign rcp.recip[1] = spd_rcp_q;
	assign rcp.recip[2] = dir_rcp_q;
	assign rcp.recip[3] = swh_rcp_q;

	always_comb begin
		// wrap direction into [0, 360) degrees; input spans about +-1024
		t = 28'(din.direction);
		for (int k = 0; k < 3; k++) begin
			if (t < 0) t = t + fati_pkg::DEG360_Q;
		end
		for (int k = 0; k < 2; k++) begin
			if (t >= fati_pkg::DEG360_Q) t = t - fati_pkg::DEG360_Q;
		end
		ent.addr     = din.entry_address;
		ent.value    = din.entry_value;
		ent.pol      = din.pol_index;
		ent.nowave   = din.wave_height < 0;
		ent.delta[0] = 33'(din.incidence) - 33'(inc_min_q);
		ent.delta[1] = 33'(din.speed) - 33'(spd_min_q);
		ent.delta[2] = 33'(t) - 33'(dir_min_q);
		ent.delta[3] = 33'(din.wave_height) - $signed({2'b00, swh_min_q});
		if (!din.command)
			ent.kind = fati_pkg::K_WRITE;
		else if (32'(din.pol_index) >= 32'(POL_COUNT))
			ent.kind = fati_pkg::K_NULL;
		else
			ent.kind = fati_pkg::K_QUERY;
	end

	assign din.ready = cnt_q != 2'd2;
	assign push      = din.valid && din.ready;
	assign head      = fifo_q[rd_ptr_q];
	assign head_v    = cnt_q != 2'd0;

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> cnt_q != 2'd0)
		else $error("queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with empty count");

endmodule

/* src/fati_back.sv */
`timescale 1ns / 1ps
// Back end: table memory, axis position unit, corner reads and a shared
// linear-step unit with a per-level pending register. Uses fati_pkg, fati_out_if.
module fati_back #(
	parameter int POL_COUNT   = 4,
	parameter int WAVE_COUNT  = 7,
	parameter int DIR_COUNT   = 16,
	parameter int SPEED_COUNT = 16,
	parameter int INC_COUNT   = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fati_pkg::entry_t head,
	input  logic             head_v,
	output logic             pop,
	input  fati_pkg::recip_t rcp,
	fati_out_if.source       dout
);

	localparam int unsigned TABLE_SIZE =
		POL_COUNT * (WAVE_COUNT + 1) * DIR_COUNT * SPEED_COUNT * INC_COUNT;
	localparam logic [fati_pkg::IDX_W-1:0] MAX_INC = fati_pkg::IDX_W'(INC_COUNT - 2);
	localparam logic [fati_pkg::IDX_W-1:0] MAX_SPD = fati_pkg::IDX_W'(SPEED_COUNT - 2);
	localparam logic [fati_pkg::IDX_W-1:0] MAX_DIR = fati_pkg::IDX_W'(DIR_COUNT - 2);
	localparam logic [fati_pkg::IDX_W-1:0] MAX_WAV = fati_pkg::IDX_W'(WAVE_COUNT - 2);

	fati_pkg::state_t state_q, state_d;

	logic [31:0]        mem_q [fati_pkg::STORE_DEPTH];
	fati_pkg::entry_t   cur_q;
	logic [1:0]         ax_q;
	logic [64:0]        amul_q;
	logic               neg_q;
	logic [fati_pkg::IDX_W-1:0] idx_q [4];
	logic signed [31:0] frac_q [4];
	logic [4:0]         cnt_q;
	logic [2:0]         lvl_q;
	logic               from_mem_q, oob_q;
	logic [31:0]        rd_q;
	logic signed [31:0] res_q, lbase_q;
	logic signed [64:0] lprod_q;
	logic signed [31:0] pend_q [4];
	logic [3:0]         pend_v_q;
	logic               out_v_q;
	logic signed [31:0] out_q;

	logic               out_free, wr_hit, last_ax, at_top;
	logic [2:0]         top;
	logic [4:0]         ncorner;
	logic signed [32:0] dsel;
	logic [32:0]        mag;
	logic [64:0]        sh;
	logic signed [50:0] pos, ip, fr_w;
	logic [fati_pkg::IDX_W-1:0] cmax, ic;
	logic signed [31:0] fr;
	logic [31:0]        wsel, dsel_i, ssel_i, isel_i, addr;
	logic signed [31:0] v;
	logic signed [32:0] diff;
	logic signed [66:0] lsum, lsh;
	logic signed [31:0] lres;

	assign top      = cur_q.nowave ? 3'd3 : 3'd4;
	assign ncorner  = cur_q.nowave ? 5'd8 : 5'd16;
	assign last_ax  = cur_q.nowave ? (ax_q == 2'd2) : (ax_q == 2'd3);
	assign at_top   = lvl_q == top;
	assign out_free = !out_v_q || dout.ready;
	assign pop      = (state_q == fati_pkg::ST_IDLE) && head_v;
	assign wr_hit   = pop && head.kind == fati_pkg::K_WRITE && 32'(head.addr) < TABLE_SIZE;

	// axis position: |d| * recip with the top magnitude bit folded in as an add
	always_comb begin
		dsel = $signed(cur_q.delta[ax_q]);
		mag  = dsel < 0 ? 33'(-dsel) : 33'(dsel);
		sh   = neg_q ? ((amul_q + 65'd65535) >> 16) : (amul_q >> 16);
		pos  = neg_q ? -$signed({2'b00, sh[48:0]}) : $signed({2'b00, sh[48:0]});
		ip   = pos >>> 16;
		unique case (ax_q)
			2'd0: cmax = MAX_INC;
			2'd1: cmax = MAX_SPD;
			2'd2: cmax = MAX_DIR;
			2'd3: cmax = MAX_WAV;
			default: cmax = MAX_INC;
		endcase
		if (ip > $signed(51'(cmax)))
			ic = cmax;
		else if (ip < 0)
			ic = '0;
		else
			ic = ip[fati_pkg::IDX_W-1:0];
		fr_w = pos - $signed(51'({ic, 16'h0000}));
		if (fr_w > 51'(fati_pkg::FRAC_LIM))
			fr = fati_pkg::FRAC_LIM;
		else if (fr_w < -51'(fati_pkg::FRAC_LIM))
			fr = -fati_pkg::FRAC_LIM;
		else
			fr = fr_w[31:0];
	end

	// corner address, row-major pol, wave, dir, speed, incidence
	always_comb begin
		wsel   = cur_q.nowave ? 32'(WAVE_COUNT) : 32'(idx_q[3]) + 32'(cnt_q[3]);
		dsel_i = 32'(idx_q[2]) + 32'(cnt_q[2]);
		ssel_i = 32'(idx_q[1]) + 32'(cnt_q[1]);
		isel_i = 32'(idx_q[0]) + 32'(cnt_q[0]);
		addr   = (((32'(cur_q.pol) * 32'(WAVE_COUNT + 1) + wsel) * 32'(DIR_COUNT) + dsel_i)
			* 32'(SPEED_COUNT) + ssel_i) * 32'(INC_COUNT) + isel_i;
	end

	always_comb begin
		v    = from_mem_q ? (oob_q ? 32'sd0 : $signed(rd_q)) : res_q;
		diff = 33'(v) - 33'(pend_q[lvl_q[1:0]]);
		lsum = (67'(lbase_q) <<< 16) + 67'(lprod_q) + 67'sd32768;
		lsh  = lsum >>> 16;
		if (lsh > 67'sd2147483647)
			lres = 32'sh7fffffff;
		else if (lsh < -67'sd2147483648)
			lres = 32'sh80000000;
		else
			lres = lsh[31:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fati_pkg::ST_IDLE: begin
				if (head_v) begin
					if (head.kind == fati_pkg::K_QUERY) state_d = fati_pkg::ST_AXMUL;
					else if (head.kind == fati_pkg::K_NULL) state_d = fati_pkg::ST_EMIT;
				end
			end
			fati_pkg::ST_AXMUL:  state_d = fati_pkg::ST_AXPOST;
			fati_pkg::ST_AXPOST: state_d = last_ax ? fati_pkg::ST_READ : fati_pkg::ST_AXMUL;
			fati_pkg::ST_READ:   state_d = fati_pkg::ST_MERGE;
			fati_pkg::ST_MERGE: begin
				if (at_top) state_d = fati_pkg::ST_EMIT;
				else if (pend_v_q[lvl_q[1:0]]) state_d = fati_pkg::ST_LFIN;
				else state_d = fati_pkg::ST_READ;
			end
			fati_pkg::ST_LFIN:   state_d = fati_pkg::ST_MERGE;
			fati_pkg::ST_EMIT:   if (out_free) state_d = fati_pkg::ST_IDLE;
			default:             state_d = fati_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= fati_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// single-port table: writes only in idle, reads only in the read step
	always_ff @(posedge clk) begin
		if (wr_hit) mem_q[head.addr] <= head.value;
		else if (state_q == fati_pkg::ST_READ) rd_q <= mem_q[addr[14:0]];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			fati_pkg::ST_IDLE: begin
				cur_q <= head;
				ax_q  <= 2'd0;
				res_q <= 32'sd0;
			end
			fati_pkg::ST_AXMUL: begin
				neg_q  <= dsel < 0;
				amul_q <= 65'({32'd0, mag[31:0]} * {32'd0, rcp.recip[ax_q]})
					+ (mag[32] ? {1'b0, rcp.recip[ax_q], 32'd0} : 65'd0);
			end
			fati_pkg::ST_AXPOST: begin
				idx_q[ax_q]  <= ic;
				frac_q[ax_q] <= fr;
				ax_q         <= ax_q + 2'd1;
				cnt_q        <= 5'd0;
				lvl_q        <= 3'd0;
			end
			fati_pkg::ST_READ: begin
				oob_q      <= addr >= fati_pkg::STORE_DEPTH;
				from_mem_q <= 1'b1;
				lvl_q      <= 3'd0;
				cnt_q      <= cnt_q + 5'd1;
			end
			fati_pkg::ST_MERGE: begin
				if (at_top) begin
					res_q <= v;
				end else if (pend_v_q[lvl_q[1:0]]) begin
					lbase_q <= pend_q[lvl_q[1:0]];
					lprod_q <= 65'(frac_q[lvl_q[1:0]]) * 65'(diff);
				end else begin
					pend_q[lvl_q[1:0]] <= v;
				end
			end
			fati_pkg::ST_LFIN: begin
				res_q      <= lres;
				lvl_q      <= lvl_q + 3'd1;
				from_mem_q <= 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (state_q == fati_pkg::ST_MERGE && !at_top)
				pend_v_q[lvl_q[1:0]] <= !pend_v_q[lvl_q[1:0]];
			if (state_q == fati_pkg::ST_EMIT && out_free)
				out_v_q <= 1'b1;
			else if (dout.ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fati_pkg::ST_EMIT && out_free) out_q <= res_q;
	end

	assign dout.valid = out_v_q;
	assign dout.value = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fati_pkg::ST_READ |-> cnt_q < ncorner)
		else $error("corner read past the last corner");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fati_pkg::ST_MERGE |-> lvl_q <= top)
		else $error("reduction level beyond top");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fati_pkg::ST_EMIT |-> pend_v_q == 4'd0)
		else $error("result emitted with partial sums pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q) == fati_pkg::ST_EMIT)
		else $error("result raised outside the emit step");

endmodule

/* src/four_axis_table_interpolator.sv */
`timescale 1ns / 1ps
// Four-axis table interpolator top level.
// Usage: configuration writes (wr_en, wr_index, wr_data) set the grid origins
// and reciprocal steps of the direction, speed, incidence and wave height axes.
// Items enter on din (valid/ready). A write item (command 0) stores one
// table word; it gives no result. A query item (command 1) gives one value
// on dout (valid/ready), the quadrilinear blend of 16 table corners (8 when
// wave height is negative), extrapolated past the grid edges.
// From leaving the input queue to the result register, a query steps through
// a multiply and a post step for each axis position, then per corner a memory
// read and merge, plus a multiply and a finish step for each linear step. The
// table is one single-port memory and the linear-step multiplier is shared.
// A two-entry queue lets din accept while the back end works.
// Reset clears registers to origin 0 and step 1.0 and empties the queue; the
// table memory is not cleared and must be written before it is read.
// A stalled dout holds its value; the back end still takes table writes and
// works the next query, but holds that result in its emit step until dout is free.
// Uses fati_pkg, fati_in_if, fati_out_if, fati_front, fati_back.
module four_axis_table_interpolator #(
	parameter int POL_COUNT   = 4,
	parameter int WAVE_COUNT  = 7,
	parameter int DIR_COUNT   = 16,
	parameter int SPEED_COUNT = 16,
	parameter int INC_COUNT   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	fati_in_if.sink     din,
	fati_out_if.source  dout,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data
);

	fati_pkg::entry_t head;
	logic             head_v;
	logic             pop;
	fati_pkg::recip_t rcp;

	fati_front #(
		.POL_COUNT(POL_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.din(din),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.pop(pop),
		.head(head),
		.head_v(head_v),
		.rcp(rcp)
	);

	fati_back #(
		.POL_COUNT(POL_COUNT),
		.WAVE_COUNT(WAVE_COUNT),
		.DIR_COUNT(DIR_COUNT),
		.SPEED_COUNT(SPEED_COUNT),
		.INC_COUNT(INC_COUNT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_v(head_v),
		.pop(pop),
		.rcp(rcp),
		.dout(dout)
	);

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for four_axis_table_interpolator: writes every table word a query
// reads ahead of that query, then runs directed and random writes and queries under
// several grid settings. Depends on fati_pkg, fati_in_if, fati_out_if and the RTL.
module tb_top;

	localparam int POLS = 4, WAVES = 7, DIRS = 16, SPEEDS = 16, INCS = 8;
	localparam int DEPTH = 32768;
	localparam longint DEG360 = 23592960;
	localparam longint FLIM = 1073741824;
	localparam longint CYCLE_LIMIT = 1000000;
	localparam int DRAIN = 200;

	typedef struct {
		bit               command;
		bit [14:0]        addr;
		bit signed [31:0] val;
		bit [1:0]         pol;
		bit signed [31:0] inc;
		bit signed [31:0] spd;
		bit signed [26:0] dir;
		bit signed [31:0] wh;
	} cmd_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [31:0] wr_data;

	fati_in_if  din();
	fati_out_if dout();

	four_axis_table_interpolator u_dut (
		.clk(clk), .arst_n(arst_n), .din(din), .dout(dout),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	// table image and grid settings as the block should hold them
	int        table_image [DEPTH];
	bit        written [DEPTH];
	longint    dir_org, spd_org, inc_org, swh_org;
	bit [31:0] dir_rcp, spd_rcp, inc_rcp, swh_rcp;

	cmd_t          pending_items[$];
	logic [31:0]   expected_values[$];
	int            n_errors, n_writes, n_queries, n_results, n_queued;
	longint        cyc;
	bit            quiet_out;  // no receiver stalls while set
	int            send_gap, stall_left;

	function automatic void axis_locate(input longint d, input bit [31:0] r, input int count,
			output int idx, output longint frac);
		bit [63:0] mag, prod;
		longint pos, i;
		mag = (d < 0) ? -d : d;
		prod = mag * {32'd0, r};
		if (d >= 0)
			pos = longint'(prod >> 16);
		else
			pos = -longint'((prod + 64'd65535) >> 16);
		i = pos >>> 16;
		if (i > count - 2)
			i = count - 2;
		if (i < 0)
			i = 0;
		pos = pos - i * 65536;
		if (pos > FLIM)
			pos = FLIM;
		if (pos < -FLIM)
			pos = -FLIM;
		idx = int'(i);
		frac = pos;
	endfunction

	function automatic longint blend(input longint v0, input longint v1, input longint f);
		longint t;
		t = ((65536 - f) * v0 + f * v1 + 32768) >>> 16;
		if (t > 64'sd2147483647)
			t = 64'sd2147483647;
		if (t < -64'sd2147483648)
			t = -64'sd2147483648;
		return t;
	endfunction

	function automatic longint corner_addr(input int p, input int w, input int d, input int s,
			input int i);
		return ((((longint'(p) * (WAVES + 1) + w) * DIRS + d) * SPEEDS + s) * INCS) + i;
	endfunction

	function automatic longint corner(input int p, input int w, input int d, input int s,
			input int i);
		longint a;
		a = corner_addr(p, w, d, s, i);
		if (a >= DEPTH)
			return 0;
		return table_image[a];
	endfunction

	function automatic longint slice_value(input int p, input int w, input int di,
			input longint df, input int si, input longint sf, input int ii, input longint nf);
		longint sv0, sv1, dv0, dv1;
		sv0 = blend(corner(p, w, di, si, ii), corner(p, w, di, si, ii + 1), nf);
		sv1 = blend(corner(p, w, di, si + 1, ii), corner(p, w, di, si + 1, ii + 1), nf);
		dv0 = blend(sv0, sv1, sf);
		sv0 = blend(corner(p, w, di + 1, si, ii), corner(p, w, di + 1, si, ii + 1), nf);
		sv1 = blend(corner(p, w, di + 1, si + 1, ii), corner(p, w, di + 1, si + 1, ii + 1), nf);
		dv1 = blend(sv0, sv1, sf);
		return blend(dv0, dv1, df);
	endfunction

	function automatic logic [31:0] query_value(input cmd_t c);
		longint dir, df, sf, nf, wf, res;
		int di, si, ii, wi;
		if (c.pol >= POLS)
			return 32'd0;
		dir = longint'(c.dir) % DEG360;
		if (dir < 0)
			dir += DEG360;
		axis_locate(dir - dir_org, dir_rcp, DIRS, di, df);
		axis_locate(longint'(c.spd) - spd_org, spd_rcp, SPEEDS, si, sf);
		axis_locate(longint'(c.inc) - inc_org, inc_rcp, INCS, ii, nf);
		if (c.wh < 0) begin
			res = slice_value(c.pol, WAVES, di, df, si, sf, ii, nf);
		end else begin
			axis_locate(longint'(c.wh) - swh_org, swh_rcp, WAVES, wi, wf);
			res = blend(slice_value(c.pol, wi, di, df, si, sf, ii, nf),
				slice_value(c.pol, wi + 1, di, df, si, sf, ii, nf), wf);
		end
		return res[31:0];
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	// coordinate near the grid: grid position in [-1.5, count+0.5] mapped back
	function automatic longint near_grid(input longint org, input bit [31:0] rcp,
			input int count);
		longint g;
		g = longint'($urandom_range(0, (count + 2) * 65536)) - 98304;
		return org + (g * 65536) / longint'(rcp);
	endfunction

	function automatic cmd_t mk_write(input bit [14:0] a, input bit [31:0] v);
		cmd_t c;
		c = '{default: '0};
		c.command = 1'b0;
		c.addr = a;
		c.val = v;
		c.pol = 2'($urandom);
		c.inc = $urandom;
		return c;
	endfunction

	function automatic cmd_t mk_query(input bit [1:0] p, input longint inc, input longint spd,
			input longint dir, input longint wh);
		cmd_t c;
		c.command = 1'b1;
		c.addr = 15'($urandom);
		c.val = $urandom;
		c.pol = p;
		c.inc = inc[31:0];
		c.spd = spd[31:0];
		c.dir = dir[26:0];
		c.wh = wh[31:0];
		return c;
	endfunction

	function automatic cmd_t random_query();
		longint inc, spd, dir, wh;
		if ($urandom_range(0, 9) < 3)
			return mk_query(2'($urandom), $signed($urandom), $signed($urandom),
				longint'($urandom_range(0, 94371840)) - 47185920, $signed($urandom));
		inc = clip(near_grid(inc_org, inc_rcp, INCS), -64'sd2147483648, 64'sd2147483647);
		spd = clip(near_grid(spd_org, spd_rcp, SPEEDS), -64'sd2147483648, 64'sd2147483647);
		dir = near_grid(dir_org, dir_rcp, DIRS) + 360 * 65536 * ($urandom_range(0, 2) - 1);
		dir = clip(dir, -47185920, 47185920);
		if ($urandom_range(0, 4) == 0)
			wh = -longint'($urandom_range(1, 32'h7FFFFFFF));
		else
			wh = clip(near_grid(swh_org, swh_rcp, WAVES), 0, 64'sd2147483647);
		return mk_query(2'($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom),
			inc, spd, dir, wh);
	endfunction

	task automatic push_write(input bit [14:0] a, input bit [31:0] v);
		written[a] = 1'b1;
		pending_items.push_back(mk_write(a, v));
		n_queued++;
	endtask

	// write every corner inside the memory that the query will read and that holds no value yet, then the query
	task automatic push_query(input cmd_t c);
		longint dir, df, sf, nf, wf, a;
		int di, si, ii, wi, wlast;
		if (c.pol < POLS) begin
			dir = longint'(c.dir) % DEG360;
			if (dir < 0)
				dir += DEG360;
			axis_locate(dir - dir_org, dir_rcp, DIRS, di, df);
			axis_locate(longint'(c.spd) - spd_org, spd_rcp, SPEEDS, si, sf);
			axis_locate(longint'(c.inc) - inc_org, inc_rcp, INCS, ii, nf);
			if (c.wh < 0) begin
				wi = WAVES;
				wlast = WAVES;
			end else begin
				axis_locate(longint'(c.wh) - swh_org, swh_rcp, WAVES, wi, wf);
				wlast = wi + 1;
			end
			for (int w = wi; w <= wlast; w++) begin
				for (int k = 0; k < 8; k++) begin
					a = corner_addr(c.pol, w, di + k[2], si + k[1], ii + k[0]);
					if (a < DEPTH && !written[a])
						push_write(15'(a), $urandom);
				end
			end
		end
		pending_items.push_back(c);
		n_queued++;
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		n_errors++;
		$display("mismatch at cycle %0d: %s got %h expected %h", cyc, what, got, want);
	endtask

	task automatic set_reg(input fati_pkg::reg_idx_t r, input logic [31:0] v);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= r;
		wr_data <= v;
		case (r)
			fati_pkg::REG_DIR_MIN: dir_org = longint'($signed(v[25:0]));
			fati_pkg::REG_DIR_RCP: dir_rcp = v;
			fati_pkg::REG_SPD_MIN: spd_org = longint'($signed(v));
			fati_pkg::REG_SPD_RCP: spd_rcp = v;
			fati_pkg::REG_INC_MIN: inc_org = longint'($signed(v));
			fati_pkg::REG_INC_RCP: inc_rcp = v;
			fati_pkg::REG_SWH_MIN: swh_org = longint'(v[30:0]);
			fati_pkg::REG_SWH_RCP: swh_rcp = v;
			default: ;
		endcase
	endtask

	task automatic set_grid(input logic [31:0] d0, d1, s0, s1, i0, i1, w0, w1);
		set_reg(fati_pkg::REG_DIR_MIN, d0);
		set_reg(fati_pkg::REG_DIR_RCP, d1);
		set_reg(fati_pkg::REG_SPD_MIN, s0);
		set_reg(fati_pkg::REG_SPD_RCP, s1);
		set_reg(fati_pkg::REG_INC_MIN, i0);
		set_reg(fati_pkg::REG_INC_RCP, i1);
		set_reg(fati_pkg::REG_SWH_MIN, w0);
		set_reg(fati_pkg::REG_SWH_RCP, w1);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || din.valid || expected_values.size() != 0)
			@(posedge clk);
		// writes leave no result behind, so let the back end settle
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic random_items(input int count);
		int stop, k;
		stop = n_queued + count;
		k = 0;
		while (n_queued < stop) begin
			if (k % 60 == 0)
				quiet_out = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 4)
				push_write(15'($urandom), $urandom);
			else
				push_query(random_query());
			k++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("FAIL");
			$finish;
		end
	end

	// sender: hold the item until the transaction, then wait the drawn gap
	always @(posedge clk or negedge arst_n) begin
		cmd_t c;
		logic next_valid;
		if (!arst_n) begin
			din.valid <= 1'b0;
			send_gap <= 0;
		end else begin
			next_valid = din.valid;
			if (din.valid && din.ready) begin
				c = pending_items.pop_front();
				if (c.command) begin
					expected_values.push_back(query_value(c));
					n_queries++;
				end else begin
					table_image[c.addr] = c.val;
					n_writes++;
				end
				next_valid = 1'b0;
				send_gap <= $urandom_range(0, 14);
			end else if (!din.valid && send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else if (!din.valid && pending_items.size() != 0) begin
				next_valid = 1'b1;
			end
			if (next_valid && pending_items.size() != 0 && !(din.valid && !din.ready)) begin
				c = pending_items[0];
				din.command <= c.command;
				din.entry_address <= c.addr;
				din.entry_value <= c.val;
				din.pol_index <= c.pol;
				din.incidence <= c.inc;
				din.speed <= c.spd;
				din.direction <= c.dir;
				din.wave_height <= c.wh;
			end
			din.valid <= next_valid && pending_items.size() != 0;
		end
	end

	// receiver: check each result, then stall for a drawn number of cycles unless quiet_out is set
	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			dout.ready <= 1'b0;
			stall_left <= 0;
		end else if (dout.valid && dout.ready) begin
			n_results++;
			if (expected_values.size() == 0) begin
				report("unexpected result", dout.value, 32'hx);
			end else begin
				want = expected_values.pop_front();
				if (dout.value !== want)
					report("value", dout.value, want);
			end
			stall_left <= quiet_out ? 0 : $urandom_range(0, 14);
			dout.ready <= quiet_out;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			dout.ready <= 1'b0;
		end else begin
			dout.ready <= 1'b1;
		end
	end

	initial begin
		cyc = 0;
		n_errors = 0;
		n_writes = 0;
		n_queries = 0;
		n_results = 0;
		n_queued = 0;
		quiet_out = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = fati_pkg::REG_DIR_MIN;
		wr_data = '0;
		din.valid = 1'b0;
		din.command = 1'b0;
		din.entry_address = '0;
		din.entry_value = '0;
		din.pol_index = '0;
		din.incidence = '0;
		din.speed = '0;
		din.direction = '0;
		din.wave_height = '0;
		dout.ready = 1'b0;
		dir_org = 0; spd_org = 0; inc_org = 0; swh_org = 0;
		dir_rcp = 65536; spd_rcp = 65536; inc_rcp = 65536; swh_rcp = 65536;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every polarization, missing wave height, wrap
		push_write(15'd0, 32'h7FFFFFFF);
		push_write(15'd1, 32'h80000000);
		push_write(15'd32767, 32'h80000000);
		push_query(mk_query(2'd0, 0, 0, 0, 0));
		push_query(mk_query(2'd1, 7 << 16, 15 << 16, 15 << 16, 6 << 16));
		push_query(mk_query(2'd2, 65536, 65536, 65536, 65536));
		push_query(mk_query(2'd3, 65536, 65536, 65536, 65536));
		push_query(mk_query(2'd0, 32'sh7FFFFFFF, -64'sd2147483648, 47185920, 0));
		push_query(mk_query(2'd1, -64'sd2147483648, 32'sh7FFFFFFF, -47185920,
			32'sh7FFFFFFF));
		push_query(mk_query(2'd0, 32768, 32768, DEG360, -1));
		push_query(mk_query(2'd1, 32768, 32768, -DEG360, -64'sd2147483648));
		push_query(mk_query(2'd1, 6 << 16, 14 << 16, -65536, -65536));
		push_query(mk_query(2'd0, -65536, -65536, 359 << 16, -65536 * 3));
		push_query(mk_query(2'd1, 9 << 16, 17 << 16, 16 << 16, 8 << 16));
		push_query(mk_query(2'd0, 0, 0, 720 << 16, 3 << 16));
		random_items(255);
		wait_idle();

		set_grid(10 << 16, 2913, 2 << 16, 32768, 20 << 16, 13107, 65536, 131072);
		random_items(255);
		wait_idle();

		set_grid(32'hFE980000, 1, 32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 1,
			32'h7FFFFFFF, 32'hFFFFFFFF);
		random_items(255);
		wait_idle();

		set_grid(32'd23592960, 32'hFFFFFFFF, 32'h7FFFFFFF, 1, 32'h80000000, 32'hFFFFFFFF,
			0, 1);
		random_items(255);
		wait_idle();

		set_grid($urandom_range(0, 60 << 16), $urandom_range(4096, 262144),
			$urandom_range(0, 5 << 16), $urandom_range(4096, 262144),
			$urandom_range(0, 30 << 16), $urandom_range(4096, 262144),
			$urandom_range(0, 2 << 16), $urandom_range(4096, 262144));
		random_items(255);
		wait_idle();

		$display("covered %0d table writes and %0d queries, %0d results checked",
			n_writes, n_queries, n_results);
		$display("grid settings: reset, scaled, both extremes and one random");
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* files.f */
src/fati_pkg.sv
src/fati_in_if.sv
src/fati_out_if.sv
src/fati_front.sv
src/fati_back.sv
src/four_axis_table_interpolator.sv
tb/sv/tb_top.sv
